/* hw/rtl/bpsd_pkg.sv */
// Shared types and constants for the byte-pair stream decoder.
package bpsd_pkg;

    localparam int STACK_DEPTH = 256;
    localparam int MAX_EXPAND  = 64;
    localparam int TBL_N       = 256;

    localparam int STK_AW = $clog2(STACK_DEPTH);
    localparam int NCW    = $clog2(MAX_EXPAND + 1);

    localparam logic [STK_AW:0] STK_FULL = (STK_AW + 1)'(STACK_DEPTH);
    localparam logic [NCW-1:0]  EXP_CAP  = NCW'(MAX_EXPAND);

    typedef enum logic [2:0] {
        PH_TYPE    = 3'd0,
        PH_SIZE_LO = 3'd1,
        PH_SIZE_HI = 3'd2,
        PH_COUNT   = 3'd3,
        PH_ENTRY   = 3'd4,
        PH_DATA    = 3'd5
    } phase_t;

    typedef enum logic [1:0] {
        ENT_CODE   = 2'd0,
        ENT_FIRST  = 2'd1,
        ENT_SECOND = 2'd2
    } entry_step_t;

    typedef enum logic [2:0] {
        ST_IDLE = 3'd0,
        ST_LOOK = 3'd1,
        ST_EVAL = 3'd2,
        ST_POP  = 3'd3,
        ST_FIN  = 3'd4
    } state_t;

endpackage

/* hw/rtl/byte_pair_stream_decoder_unit.sv */
// Byte-pair stream decoder: block parser, pair tables and stack-based expansion sequencer.
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+----------------------------------
//   in      | sink      | in_valid / in_stall | in_byte, in_last
//   out     | source    | out_valid/out_stall | out_byte, run_last, expand_error
//
// Header, table and literal data bytes are handled in ST_IDLE as each is accepted.
// A pair-coded data byte runs ST_LOOK and ST_EVAL per table lookup, ST_POP per stack pop and
// ST_FIN to close the beat, held by output stalls; ST_LOOK waits on the registered table read.
// Pair tables clear at a coded block start through per-entry valid bits.
// in_stall stays high while an expansion runs or the output register is held.
module byte_pair_stream_decoder_unit
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] in_byte,
    input  logic       in_last,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_byte,
    output logic       run_last,
    output logic       expand_error
);
    import bpsd_pkg::*;

    state_t            state_reg, state_next;
    phase_t            phase_reg, phase_next;
    logic              coded_reg, coded_next;
    logic [15:0]       bytes_left_reg, bytes_left_next;
    logic [7:0]        pairs_left_reg, pairs_left_next;
    entry_step_t       step_reg, step_next;
    logic [7:0]        entry_code_reg, entry_code_next;
    logic [7:0]        entry_first_reg, entry_first_next;
    logic [TBL_N-1:0]  tbl_valid_reg, tbl_valid_next;
    logic [7:0]        c_reg, c_next;
    logic [STK_AW:0]   top_reg, top_next;
    logic [NCW-1:0]    n_reg, n_next;
    logic [7:0]        pend_reg, pend_next;
    logic              pend_valid_reg, pend_valid_next;
    logic              err_reg, err_next;
    logic              out_valid_reg, out_valid_next;
    logic [7:0]        out_byte_reg, out_byte_next;
    logic              run_last_reg, run_last_next;
    logic              out_err_reg, out_err_next;

    logic [7:0]        first_mem [TBL_N];
    logic [7:0]        second_mem [TBL_N];
    logic [7:0]        stack_mem [STACK_DEPTH];
    logic [7:0]        rd_first_reg, rd_second_reg, stk_rd_reg;
    logic              rd_valid_reg;

    logic              tbl_we, stk_we, out_free, accept;
    logic [7:0]        eff_first, eff_second, size_word_hi;
    logic [STK_AW-1:0] stk_raddr;

    assign out_free   = !out_valid_reg || !out_stall;
    assign in_stall   = (state_reg != ST_IDLE) || !out_free;
    assign accept     = in_valid && !in_stall;
    assign eff_first  = rd_valid_reg ? rd_first_reg : c_reg;
    assign eff_second = rd_valid_reg ? rd_second_reg : 8'h00;
    assign stk_raddr  = top_reg[STK_AW-1:0] - STK_AW'(1);
    assign size_word_hi = in_byte;

    assign out_valid    = out_valid_reg;
    assign out_byte     = out_byte_reg;
    assign run_last     = run_last_reg;
    assign expand_error = out_err_reg;

    always_ff @(posedge clk)
    begin
        if (tbl_we)
        begin
            first_mem[entry_code_reg]  <= entry_first_reg;
            second_mem[entry_code_reg] <= in_byte;
        end
        rd_first_reg  <= first_mem[c_reg];
        rd_second_reg <= second_mem[c_reg];
        if (stk_we)
        begin
            stack_mem[top_reg[STK_AW-1:0]] <= eff_second;
        end
        stk_rd_reg <= stack_mem[stk_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            phase_reg       <= PH_TYPE;
            coded_reg       <= 1'b0;
            bytes_left_reg  <= '0;
            pairs_left_reg  <= '0;
            step_reg        <= ENT_CODE;
            entry_code_reg  <= '0;
            entry_first_reg <= '0;
            tbl_valid_reg   <= '0;
            rd_valid_reg    <= 1'b0;
            c_reg           <= '0;
            top_reg         <= '0;
            n_reg           <= '0;
            pend_reg        <= '0;
            pend_valid_reg  <= 1'b0;
            err_reg         <= 1'b0;
            out_valid_reg   <= 1'b0;
            out_byte_reg    <= '0;
            run_last_reg    <= 1'b0;
            out_err_reg     <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            phase_reg       <= phase_next;
            coded_reg       <= coded_next;
            bytes_left_reg  <= bytes_left_next;
            pairs_left_reg  <= pairs_left_next;
            step_reg        <= step_next;
            entry_code_reg  <= entry_code_next;
            entry_first_reg <= entry_first_next;
            tbl_valid_reg   <= tbl_valid_next;
            rd_valid_reg    <= tbl_valid_reg[c_reg];
            c_reg           <= c_next;
            top_reg         <= top_next;
            n_reg           <= n_next;
            pend_reg        <= pend_next;
            pend_valid_reg  <= pend_valid_next;
            err_reg         <= err_next;
            out_valid_reg   <= out_valid_next;
            out_byte_reg    <= out_byte_next;
            run_last_reg    <= run_last_next;
            out_err_reg     <= out_err_next;
        end
    end

    always_comb
    begin
        state_next       = state_reg;
        phase_next       = phase_reg;
        coded_next       = coded_reg;
        bytes_left_next  = bytes_left_reg;
        pairs_left_next  = pairs_left_reg;
        step_next        = step_reg;
        entry_code_next  = entry_code_reg;
        entry_first_next = entry_first_reg;
        tbl_valid_next   = tbl_valid_reg;
        c_next           = c_reg;
        top_next         = top_reg;
        n_next           = n_reg;
        pend_next        = pend_reg;
        pend_valid_next  = pend_valid_reg;
        err_next         = err_reg;
        out_valid_next   = out_valid_reg && out_stall;
        out_byte_next    = out_byte_reg;
        run_last_next    = run_last_reg;
        out_err_next     = out_err_reg;
        tbl_we           = 1'b0;
        stk_we           = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (phase_reg)
                        PH_SIZE_LO:
                        begin
                            bytes_left_next = {8'h00, in_byte};
                            phase_next      = PH_SIZE_HI;
                        end
                        PH_SIZE_HI:
                        begin
                            bytes_left_next = {size_word_hi, bytes_left_reg[7:0]};
                            if (coded_reg)
                            begin
                                phase_next = PH_COUNT;
                            end
                            else if ({size_word_hi, bytes_left_reg[7:0]} != 16'h0000)
                            begin
                                phase_next = PH_DATA;
                            end
                            else
                            begin
                                phase_next = PH_TYPE;
                            end
                        end
                        PH_COUNT:
                        begin
                            pairs_left_next = in_byte;
                            step_next       = ENT_CODE;
                            if (in_byte != 8'h00)
                            begin
                                phase_next = PH_ENTRY;
                            end
                            else
                            begin
                                phase_next = (bytes_left_reg != 16'h0000) ? PH_DATA : PH_TYPE;
                            end
                        end
                        PH_ENTRY:
                        begin
                            case (step_reg)
                                ENT_CODE:
                                begin
                                    entry_code_next = in_byte;
                                    step_next       = ENT_FIRST;
                                end
                                ENT_FIRST:
                                begin
                                    entry_first_next = in_byte;
                                    step_next        = ENT_SECOND;
                                end
                                default:
                                begin
                                    tbl_we                         = 1'b1;
                                    tbl_valid_next[entry_code_reg] = 1'b1;
                                    step_next                      = ENT_CODE;
                                    pairs_left_next                = pairs_left_reg - 8'd1;
                                    if (pairs_left_reg == 8'h01)
                                    begin
                                        phase_next = (bytes_left_reg != 16'h0000) ?
                                                     PH_DATA : PH_TYPE;
                                    end
                                end
                            endcase
                        end
                        PH_DATA:
                        begin
                            bytes_left_next = bytes_left_reg - 16'd1;
                            if (bytes_left_reg == 16'h0001)
                            begin
                                phase_next = PH_TYPE;
                            end
                            if (coded_reg)
                            begin
                                c_next          = in_byte;
                                top_next        = '0;
                                n_next          = '0;
                                pend_valid_next = 1'b0;
                                err_next        = 1'b0;
                                state_next      = ST_LOOK;
                            end
                            else
                            begin
                                out_valid_next = 1'b1;
                                out_byte_next  = in_byte;
                                run_last_next  = 1'b1;
                                out_err_next   = 1'b0;
                            end
                        end
                        default:
                        begin
                            coded_next = (in_byte != 8'h00);
                            if (in_byte != 8'h00)
                            begin
                                tbl_valid_next = '0;
                            end
                            bytes_left_next = '0;
                            pairs_left_next = '0;
                            step_next       = ENT_CODE;
                            phase_next      = PH_SIZE_LO;
                        end
                    endcase
                    if (in_last)
                    begin
                        phase_next = PH_TYPE;
                    end
                end
            end
            ST_LOOK:
            begin
                state_next = ST_EVAL;
            end
            ST_EVAL:
            begin
                if (eff_first == c_reg)
                begin
                    if (n_reg >= EXP_CAP)
                    begin
                        err_next   = 1'b1;
                        state_next = ST_FIN;
                    end
                    else if (!pend_valid_reg || out_free)
                    begin
                        if (pend_valid_reg)
                        begin
                            out_valid_next = 1'b1;
                            out_byte_next  = pend_reg;
                            run_last_next  = 1'b0;
                            out_err_next   = 1'b0;
                        end
                        pend_next       = c_reg;
                        pend_valid_next = 1'b1;
                        n_next          = n_reg + NCW'(1);
                        if (top_reg == '0)
                        begin
                            state_next = ST_FIN;
                        end
                        else
                        begin
                            top_next   = top_reg - (STK_AW + 1)'(1);
                            state_next = ST_POP;
                        end
                    end
                end
                else if (top_reg == STK_FULL)
                begin
                    err_next   = 1'b1;
                    state_next = ST_FIN;
                end
                else
                begin
                    stk_we     = 1'b1;
                    top_next   = top_reg + (STK_AW + 1)'(1);
                    c_next     = eff_first;
                    state_next = ST_LOOK;
                end
            end
            ST_POP:
            begin
                c_next     = stk_rd_reg;
                state_next = ST_LOOK;
            end
            ST_FIN:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_byte_next   = pend_valid_reg ? pend_reg : 8'h00;
                    run_last_next   = 1'b1;
                    out_err_next    = err_reg;
                    pend_valid_next = 1'b0;
                    top_next        = '0;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    a_stack_bound: assert property (@(posedge clk) disable iff (!rst_n)
        top_reg <= STK_FULL)
        else $error("stack pointer past depth");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        n_reg <= EXP_CAP)
        else $error("expansion count past cap");

    a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> (top_reg == '0))
        else $error("stack not empty between beats");

    a_fin_emits: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FIN && out_free) |=> (out_valid_reg && run_last_reg))
        else $error("closing beat not presented");

    a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_err_reg) |-> run_last_reg)
        else $error("error flag on a non-final beat");

endmodule
